>>> sv/sparse_matrix_vector_mac_unit_defines.svh
// ----------------------------------------------------------------------------
// sparse matrix vector mac unit - assertion macros
// shared macros for the concurrent assertions of the checker
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_VECTOR_MAC_UNIT_DEFINES_SVH
`define SPARSE_MATRIX_VECTOR_MAC_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMVM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SMVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/smvm_pkg.sv
// ----------------------------------------------------------------------------
// smvm_pkg
// item types, op codes, widths and saturation helper of the sparse mac unit
// ----------------------------------------------------------------------------
package smvm_pkg;

  localparam int IDX_W            = 10;
  localparam int VAL_W            = 32;
  localparam int ROW_W            = 16;
  localparam int Q_FRAC           = 24;
  localparam int PROD_W           = 2 * VAL_W;
  localparam int PRE_SUM_W        = PROD_W + 2;
  localparam int PRE_W            = PRE_SUM_W - Q_FRAC;
  localparam int ACC_W            = PRE_W + 1;
  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int OUT_FIFO_DEPTH   = 8;
  localparam int FIFO_PTR_W       = $clog2(OUT_FIFO_DEPTH);
  localparam int OCC_W            = $clog2(OUT_FIFO_DEPTH + 1);

  localparam logic signed [PRE_SUM_W-1:0] RND_HALF = PRE_SUM_W'(1) << (Q_FRAC - 1);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_END_ROW = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value_re;
    logic signed [VAL_W-1:0] value_im;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_number;
    logic signed [VAL_W-1:0] sum_re;
    logic signed [VAL_W-1:0] sum_im;
  } out_item_t;

  typedef struct packed {
    logic vld;
    logic eor;
  } stage_ctl_t;

  // clamp a wide signed value to the signed VAL_W range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-VAL_W:0] hi;
    logic signed [VAL_W-1:0] res;
    hi = v[ACC_W-1:VAL_W-1];
    if ((&hi) || !(|hi)) begin
      res = v[VAL_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> sv/smvm_vec_ram.sv
// ----------------------------------------------------------------------------
// smvm_vec_ram
// single-port vector store, complex word per entry, registered read
// ----------------------------------------------------------------------------
module smvm_vec_ram #(
  parameter int DEPTH = smvm_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [2*smvm_pkg::VAL_W-1:0]               wdata,
  output logic [2*smvm_pkg::VAL_W-1:0]               rdata
);

  logic [2*smvm_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> sv/smvm_out_fifo.sv
// ----------------------------------------------------------------------------
// smvm_out_fifo
// small result queue between the accumulator and the out channel
// ----------------------------------------------------------------------------
module smvm_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  smvm_pkg::out_item_t  push_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smvm_pkg::out_item_t  out_data
);

  smvm_pkg::out_item_t                 mem [smvm_pkg::OUT_FIFO_DEPTH];
  logic [smvm_pkg::FIFO_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [smvm_pkg::FIFO_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [smvm_pkg::OCC_W-1:0]          cnt_r, cnt_nxt;
  logic                                pop;

  // push never meets a full queue: the top level holds back items by credit
  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + smvm_pkg::OCC_W'(push) - smvm_pkg::OCC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/sparse_matrix_vector_mac_unit.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_mac_unit
// complex row-compressed sparse matrix times vector, q8.24, saturating sums
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_ready     | in_data  (op, index, value_re/im)
//  out     | output    | out_valid / out_ready   | out_data (row_number, sum_re/im)
//  cfg     | input     | cfg_wr_en, no wait      | cfg_wr_data (first_row)
//
//  one item per cycle while in_ready is high; an end-of-row item passes the
//  memory read, multiply, round and accumulate stages, then waits in an
//  8-entry result queue
//  in_ready drops only while 8 results are in flight or queued
//  synchronous active-low reset clears the row sum, row counter, stage valids, credit count and queue;
//  the vector store holds no reset and needs no clearing pass
// ----------------------------------------------------------------------------
module sparse_matrix_vector_mac_unit #(
  parameter int VECTOR_DEPTH = smvm_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  smvm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output smvm_pkg::out_item_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [smvm_pkg::ROW_W-1:0]     cfg_wr_data
);

  localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int EXT_W  = (ADDR_W > smvm_pkg::IDX_W) ? ADDR_W : smvm_pkg::IDX_W;
  localparam int VW     = smvm_pkg::VAL_W;

  // ---------------------------------------------------------------- accept
  logic              in_fire;
  logic              out_fire;
  logic [EXT_W-1:0]  idx_ext;
  logic              idx_ok;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic              ram_re;
  logic [2*VW-1:0]   ram_rdata;
  logic              is_nz;
  logic              is_eor;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;
  assign is_nz    = (in_data.op == smvm_pkg::OP_NONZERO);
  assign is_eor   = (in_data.op == smvm_pkg::OP_END_ROW);
  assign idx_ext  = EXT_W'(in_data.index);
  // columns past the store read as zero, loads past it are dropped
  assign idx_ok   = (32'(in_data.index) < 32'(VECTOR_DEPTH));
  assign ram_addr = idx_ext[ADDR_W-1:0];
  assign ram_we   = in_fire & (in_data.op == smvm_pkg::OP_LOAD) & idx_ok;
  assign ram_re   = in_fire & is_nz & idx_ok;

  // a load and a later nonzero to the same column meet at the same port in
  // order, so the read always sees the newest write
  smvm_vec_ram #(
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata ({in_data.value_re, in_data.value_im}),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 1
  // loads and unused op codes leave the pipe here
  smvm_pkg::stage_ctl_t   s1_ctl_r, s1_ctl_nxt;
  logic                   s1_ok_r;
  logic signed [VW-1:0]   s1_a_r, s1_b_r;
  logic signed [VW-1:0]   x_re, x_im;

  assign s1_ctl_nxt.vld = in_fire & (is_nz | is_eor);
  assign s1_ctl_nxt.eor = is_eor;

  always_ff @(posedge clk) begin
    s1_ok_r <= idx_ok;
    s1_a_r  <= in_data.value_re;
    s1_b_r  <= in_data.value_im;
  end

  assign x_re = s1_ok_r ? ram_rdata[2*VW-1:VW] : '0;
  assign x_im = s1_ok_r ? ram_rdata[VW-1:0]    : '0;

  // ---------------------------------------------------------------- stage 2
  // four exact partial products, one multiplier each
  smvm_pkg::stage_ctl_t                   s2_ctl_r;
  logic signed [smvm_pkg::PROD_W-1:0]     p_ac_r, p_bd_r, p_ad_r, p_bc_r;
  logic signed [VW-1:0]                   s2_pri_re_r, s2_pri_im_r;

  always_ff @(posedge clk) begin
    p_ac_r      <= s1_a_r * x_re;
    p_bd_r      <= s1_b_r * x_im;
    p_ad_r      <= s1_a_r * x_im;
    p_bc_r      <= s1_b_r * x_re;
    s2_pri_re_r <= s1_a_r;
    s2_pri_im_r <= s1_b_r;
  end

  // ---------------------------------------------------------------- stage 3
  // combine and round half up to q18.24
  smvm_pkg::stage_ctl_t                    s3_ctl_r;
  logic signed [smvm_pkg::PRE_SUM_W-1:0]   t_re, t_im;
  logic signed [smvm_pkg::PRE_W-1:0]       pre_re_r, pre_im_r;
  logic signed [VW-1:0]                    s3_pri_re_r, s3_pri_im_r;

  always_comb begin
    t_re = smvm_pkg::PRE_SUM_W'(p_ac_r) - smvm_pkg::PRE_SUM_W'(p_bd_r) + smvm_pkg::RND_HALF;
    t_im = smvm_pkg::PRE_SUM_W'(p_ad_r) + smvm_pkg::PRE_SUM_W'(p_bc_r) + smvm_pkg::RND_HALF;
  end

  always_ff @(posedge clk) begin
    pre_re_r    <= t_re[smvm_pkg::Q_FRAC +: smvm_pkg::PRE_W];
    pre_im_r    <= t_im[smvm_pkg::Q_FRAC +: smvm_pkg::PRE_W];
    s3_pri_re_r <= s2_pri_re_r;
    s3_pri_im_r <= s2_pri_im_r;
  end

  // ---------------------------------------------------------------- stage 4
  // running row sum; end of row adds the prior, emits and clears
  logic signed [VW-1:0]                sum_re_r, sum_re_nxt;
  logic signed [VW-1:0]                sum_im_r, sum_im_nxt;
  logic [smvm_pkg::ROW_W-1:0]          row_cnt_r, row_cnt_nxt;
  logic signed [smvm_pkg::ACC_W-1:0]   acc_re, acc_im;
  logic signed [smvm_pkg::ACC_W-1:0]   fin_re, fin_im;
  logic                                push;
  smvm_pkg::out_item_t                 push_data;

  always_comb begin
    acc_re = smvm_pkg::ACC_W'(sum_re_r) + smvm_pkg::ACC_W'(pre_re_r);
    acc_im = smvm_pkg::ACC_W'(sum_im_r) + smvm_pkg::ACC_W'(pre_im_r);
    fin_re = smvm_pkg::ACC_W'(s3_pri_re_r) + smvm_pkg::ACC_W'(sum_re_r);
    fin_im = smvm_pkg::ACC_W'(s3_pri_im_r) + smvm_pkg::ACC_W'(sum_im_r);

    push                 = s3_ctl_r.vld & s3_ctl_r.eor;
    push_data.row_number = row_cnt_r;
    push_data.sum_re     = smvm_pkg::sat_val(fin_re);
    push_data.sum_im     = smvm_pkg::sat_val(fin_im);

    sum_re_nxt  = sum_re_r;
    sum_im_nxt  = sum_im_r;
    row_cnt_nxt = row_cnt_r;
    if (s3_ctl_r.vld) begin
      if (s3_ctl_r.eor) begin
        sum_re_nxt  = '0;
        sum_im_nxt  = '0;
        row_cnt_nxt = row_cnt_r + 1'b1;
      end else begin
        sum_re_nxt = smvm_pkg::sat_val(acc_re);
        sum_im_nxt = smvm_pkg::sat_val(acc_im);
      end
    end
    // first_row is to be written only while idle; the block itself does not enforce it
    if (cfg_wr_en) begin
      row_cnt_nxt = cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------- credit
  // results in flight plus queued never exceed the queue depth
  logic [smvm_pkg::OCC_W-1:0] occ_r, occ_nxt;

  assign occ_nxt  = occ_r + smvm_pkg::OCC_W'(in_fire & is_eor) - smvm_pkg::OCC_W'(out_fire);
  assign in_ready = (occ_r < smvm_pkg::OCC_W'(smvm_pkg::OUT_FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r  <= '0;
      s2_ctl_r  <= '0;
      s3_ctl_r  <= '0;
      sum_re_r  <= '0;
      sum_im_r  <= '0;
      row_cnt_r <= '0;
      occ_r     <= '0;
    end else begin
      s1_ctl_r  <= s1_ctl_nxt;
      s2_ctl_r  <= s1_ctl_r;
      s3_ctl_r  <= s2_ctl_r;
      sum_re_r  <= sum_re_nxt;
      sum_im_r  <= sum_im_nxt;
      row_cnt_r <= row_cnt_nxt;
      occ_r     <= occ_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  smvm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/smvm_chk.sv
// ----------------------------------------------------------------------------
// smvm_chk
// port-level checker for the sparse mac unit, bound to the top level
// ----------------------------------------------------------------------------
`include "sparse_matrix_vector_mac_unit_defines.svh"

module smvm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input smvm_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input smvm_pkg::out_item_t         out_data,
  input logic                        cfg_wr_en,
  input logic [smvm_pkg::ROW_W-1:0]  cfg_wr_data
);

  logic [smvm_pkg::ROW_W-1:0] exp_row_r, exp_row_nxt;
  logic [7:0]                 pend_r, pend_nxt;
  logic                       in_eor;
  logic                       out_fire;

  assign in_eor   = in_valid & in_ready & (in_data.op == smvm_pkg::OP_END_ROW);
  assign out_fire = out_valid & out_ready;

  always_comb begin
    pend_nxt    = pend_r + 8'(in_eor) - 8'(out_fire);
    exp_row_nxt = exp_row_r;
    if (out_fire) begin
      exp_row_nxt = exp_row_r + 1'b1;
    end
    if (cfg_wr_en) begin
      exp_row_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r <= '0;
      pend_r    <= '0;
    end else begin
      exp_row_r <= exp_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  `SMVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out item changed while stalled")
  `SMVM_ASSERT_SAME(a_row_seq, out_valid, out_data.row_number == exp_row_r, "row number out of sequence")
  `SMVM_ASSERT_SAME(a_no_extra, out_valid, pend_r != 8'd0, "result without end-of-row item")
  `SMVM_ASSERT_SAME(a_ready_after_rst, $rose(rst_n), in_ready, "not ready after reset")

endmodule

bind sparse_matrix_vector_mac_unit smvm_chk u_smvm_chk (.*);

>>> verif/mac_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mac_check_pkg
// row result predictor and scoreboard for the sparse matrix vector mac unit
// ----------------------------------------------------------------------------
package mac_check_pkg;
  import smvm_pkg::*;

  // wide enough for an exact complex product term sum
  localparam int WIDE_W = 2 * VAL_W + 2;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam wide_t ROUND_HALF = wide_t'(1) <<< (Q_FRAC - 1);

  class row_scoreboard;
    val_t             vec_re [VECTOR_DEPTH_DEF];
    val_t             vec_im [VECTOR_DEPTH_DEF];
    val_t             acc_re;
    val_t             acc_im;
    logic [ROW_W-1:0] next_row;
    out_item_t        expected_rows [$];
    int               fails;

    function new();
      acc_re   = '0;
      acc_im   = '0;
      next_row = '0;
      fails    = 0;
    endfunction

    function wide_t round_q(wide_t p);
      return (p + ROUND_HALF) >>> Q_FRAC;
    endfunction

    function val_t clamp(wide_t v);
      if (v > wide_t'(32'sh7FFFFFFF)) begin
        return 32'sh7FFFFFFF;
      end
      if (v < wide_t'(32'sh80000000)) begin
        return 32'sh80000000;
      end
      return val_t'(v);
    endfunction

    // a register write restarts the row numbering
    function void set_first_row(logic [ROW_W-1:0] v);
      next_row = v;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    function void note_input(in_item_t it);
      wide_t     a, b, c, d, p_re, p_im;
      out_item_t want;
      a = wide_t'($signed(it.value_re));
      b = wide_t'($signed(it.value_im));
      case (it.op)
        OP_LOAD: begin
          vec_re[it.index] = it.value_re;
          vec_im[it.index] = it.value_im;
        end
        OP_NONZERO: begin
          c      = wide_t'(vec_re[it.index]);
          d      = wide_t'(vec_im[it.index]);
          p_re   = round_q(a * c - b * d);
          p_im   = round_q(a * d + b * c);
          acc_re = clamp(wide_t'(acc_re) + p_re);
          acc_im = clamp(wide_t'(acc_im) + p_im);
        end
        OP_END_ROW: begin
          want.row_number = next_row;
          want.sum_re     = clamp(a + wide_t'(acc_re));
          want.sum_im     = clamp(b + wide_t'(acc_im));
          expected_rows.push_back(want);
          next_row = next_row + 1'b1;
          acc_re   = '0;
          acc_im   = '0;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fails++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_rows.size() == 0) begin
        report($sformatf("row %0d arrived with no row pending", got.row_number));
        return;
      end
      want = expected_rows.pop_front();
      if (got.row_number !== want.row_number) begin
        report($sformatf("row number %0d, expected %0d", got.row_number, want.row_number));
      end
      if (got.sum_re !== want.sum_re) begin
        report($sformatf("row %0d sum_re %h, expected %h",
                         want.row_number, got.sum_re, want.sum_re));
      end
      if (got.sum_im !== want.sum_im) begin
        report($sformatf("row %0d sum_im %h, expected %h",
                         want.row_number, got.sum_im, want.sum_im));
      end
    endtask
  endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// streams vector loads, nonzeros and row ends into the sparse mac unit with
// random gaps and output stalls, and checks every row result against a
// predictor in the scoreboard
// ----------------------------------------------------------------------------
module tb_top;
  import smvm_pkg::*;
  import mac_check_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 12;    // pipeline is 4 deep, leave margin
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;

  // op code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam val_t VMAX = 32'sh7FFFFFFF;
  localparam val_t VMIN = 32'sh80000000;
  localparam val_t ONE  = 32'sh01000000;  // 1.0 in q8.24
  localparam val_t HALF = 32'sh00800000;  // 0.5 in q8.24

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [ROW_W-1:0] cfg_wr_data = '0;

  row_scoreboard    sb;
  int               quiet_cycles   = 0;
  int               src_gap_pct    = 0;
  int               sink_stall_pct = 0;
  logic             hold_off_req   = 1'b0;

  // columns with a loaded vector element, so nonzeros never read a hole
  bit               col_loaded [VECTOR_DEPTH_DEF];
  logic [IDX_W-1:0] loaded_cols [$];

  always #1 clk = ~clk;

  sparse_matrix_vector_mac_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  // value mix: small fixed point numbers, shifted words, full words, extremes
  function automatic val_t rand_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) begin
      return val_t'($urandom_range(0, 32'd134217728)) - val_t'(32'sd67108864);
    end else if (r < 60) begin
      return val_t'($urandom) >>> $urandom_range(1, 12);
    end else if (r < 90) begin
      return val_t'($urandom);
    end
    case ($urandom_range(4))
      0:       return VMAX;
      1:       return VMIN;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [IDX_W-1:0] idx,
                                         val_t re, val_t im);
    in_item_t it;
    it.op       = op;
    it.index    = idx;
    it.value_re = re;
    it.value_im = im;
    return it;
  endfunction

  // drop valid and stay idle for the requested gap
  task automatic idle_in(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // present one item and hold it until taken; valid stays high on return
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer(input in_item_t it);
    if (it.op == OP_LOAD && !col_loaded[it.index]) begin
      col_loaded[it.index] = 1'b1;
      loaded_cols.push_back(it.index);
    end
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      idle_in(pick_gap());
    end
    send_item(it);
  endtask

  // one well formed row: up to two fresh loads, up to max_terms nonzeros on loaded columns, then the row end
  task automatic send_row(input int max_terms);
    int               n_loads;
    int               n_terms;
    logic [IDX_W-1:0] col;
    n_loads = ($urandom_range(99) < 30) ? $urandom_range(1, 2) : 0;
    repeat (n_loads) begin
      offer(make_item(OP_LOAD, IDX_W'($urandom), rand_value(), rand_value()));
    end
    n_terms = (loaded_cols.size() == 0) ? 0 : $urandom_range(0, max_terms);
    repeat (n_terms) begin
      col = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
      offer(make_item(OP_NONZERO, col, rand_value(), rand_value()));
    end
    offer(make_item(OP_END_ROW, IDX_W'($urandom), rand_value(), rand_value()));
  endtask

  // rows with a sprinkle of ignored ops and stray loads
  task automatic run_rows(input int n_items);
    int          sent;
    int unsigned r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 6) begin
        offer(make_item(OP_UNUSED, IDX_W'($urandom), val_t'($urandom), val_t'($urandom)));
        sent++;
      end else if (r < 12) begin
        offer(make_item(OP_LOAD, IDX_W'($urandom), rand_value(), rand_value()));
        sent++;
      end else begin
        send_row(6);
        sent += 4;   // rough mean row length
      end
    end
  endtask

  // stop sending, wait for every pending row, then let the pipeline empty
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic config_first_row(input logic [ROW_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_first_row(v);
  endtask

  // result side: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
        out_ready <= 1'b0;
        repeat (pick_gap() - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: results are checked before a same-edge input is noted
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
    if (rst_n && in_valid && in_ready) begin
      sb.note_input(in_data);
    end
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL sparse_matrix_vector_mac_unit");
    $finish;
  end

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, first_row left at its reset value of zero
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    // empty row straight after reset
    offer(make_item(OP_END_ROW, '0, '0, '0));
    // ignored op with every bit set
    offer(make_item(OP_UNUSED, '1, -1, -1));
    // vector extremes at both ends of the store
    offer(make_item(OP_LOAD, 10'd0, VMAX, VMAX));
    offer(make_item(OP_LOAD, 10'd1023, VMIN, VMIN));
    offer(make_item(OP_LOAD, 10'd1, ONE, '0));
    offer(make_item(OP_LOAD, 10'd2, '0, -ONE));
    offer(make_item(OP_LOAD, 10'd3, 32'sd1, -32'sd1));
    // huge products, sum saturates high
    offer(make_item(OP_NONZERO, 10'd0, VMAX, VMAX));
    offer(make_item(OP_NONZERO, 10'd1023, VMIN, VMIN));
    offer(make_item(OP_END_ROW, '0, VMAX, VMAX));
    // exact half lsb products, both signs, round half up
    offer(make_item(OP_NONZERO, 10'd3, HALF, '0));
    offer(make_item(OP_NONZERO, 10'd3, -HALF, '0));
    offer(make_item(OP_END_ROW, '0, '0, '0));
    // sum saturates low, prior at the negative extreme
    offer(make_item(OP_NONZERO, 10'd1023, VMAX, VMIN));
    offer(make_item(OP_NONZERO, 10'd2, VMIN, '0));
    offer(make_item(OP_END_ROW, '0, VMIN, VMIN));
    // identity multiply on a full random element
    offer(make_item(OP_LOAD, 10'd512, val_t'($urandom), val_t'($urandom)));
    offer(make_item(OP_NONZERO, 10'd512, ONE, '0));
    offer(make_item(OP_NONZERO, 10'd1, val_t'($urandom), val_t'($urandom)));
    offer(make_item(OP_END_ROW, '0, val_t'($urandom), val_t'($urandom)));
    offer(make_item(OP_UNUSED, IDX_W'($urandom), val_t'($urandom), val_t'($urandom)));
    // empty row with mixed extremes
    offer(make_item(OP_END_ROW, '1, VMIN, VMAX));
    drain_results();

    // top row number, wraps to zero after the first row
    config_first_row(16'hFFFF);
    src_gap_pct    = 25;
    sink_stall_pct = 25;
    run_rows(300);
    drain_results();

    // long result hold-off fills the queue and stalls the input
    config_first_row(16'h0000);
    src_gap_pct    = 10;
    sink_stall_pct = 10;
    hold_off_req   = 1'b1;
    repeat (40) send_row(1);
    run_rows(140);
    // sender waits for every row before going on
    drain_results();
    run_rows(140);
    drain_results();

    // back to back on both sides
    config_first_row(ROW_W'($urandom));
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    run_rows(300);
    drain_results();

    // heavy idling on both sides
    config_first_row(16'hFFFE);
    src_gap_pct    = 50;
    sink_stall_pct = 50;
    run_rows(300);
    drain_results();

    if (sb.fails == 0) begin
      $display("PASS sparse_matrix_vector_mac_unit");
    end else begin
      $display("FAIL sparse_matrix_vector_mac_unit");
    end
    $finish;
  end

endmodule
